FILE: rtl/lse_pkg.sv
// Package for the LSB extraction unit: field widths, result kinds, phase codes
// and the result record passed from the control logic to the top level.
// No dependencies.
`default_nettype none

package lse_pkg;

  localparam int unsigned HdrWordBits = 32;
  localparam int unsigned CntW        = $clog2(HdrWordBits + 1);
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned HdrFields   = 5 + 1;

  localparam logic [2:0] LastHdrIdx        = 3'(HdrFields - 1);
  localparam logic [3:0] MaxBitsPerCarrier = 4'(ByteBits);

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    KindInfo    = 3'd0,
    KindHeight  = 3'd1,
    KindWidth   = 3'd2,
    KindBpp     = 3'd3,
    KindStored  = 3'd4,
    KindPayLen  = 3'd5,
    KindPayload = 3'd6,
    KindError   = 3'd7
  } kind_e;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhCount   = 5'b00010,
    PhHeader  = 5'b00100,
    PhPayload = 5'b01000,
    PhDone    = 5'b10000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/lsb_stego_extract_unit.sv
// Top level of the LSB extraction unit: input register, extraction control
// and result register. Depends on lse_pkg and lse_ctrl.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------
//   in      | in_valid_i  | in_stall_o  | start_req_i, carrier_byte_i
//   out     | out_valid_o | out_stall_i | kind_o, value_o, last_o
//
// One item per cycle while the input is not stalled; a result passes through the
// input register, then the result register.
// Reset clears the register valids and the extraction phase (waits for start).
// A stalled result holds the result register and the input register; the
// input stalls only while both are full.
`default_nettype none

module lsb_stego_extract_unit import lse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [7:0]  carrier_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic        last_o
);

  logic       s1_valid_q;
  logic       s1_start_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  res_t       res_q;
  logic       adv;
  logic       fire;
  logic       res_valid;
  res_t       res;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_start_q <= start_req_i;
      s1_byte_q  <= carrier_byte_i;
    end
  end

  lse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .start_i     (s1_start_q),
    .byte_i      (s1_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fire && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign value_o     = res_q.value;
  assign last_o      = res_q.last;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register can advance");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KindError)) |-> (last_o && (value_o == 32'd0)))
    else $error("error result not last or nonzero");

  a_payload_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KindPayload)) |-> (value_o[31:8] == 24'd0))
    else $error("payload byte wider than 8 bits");

  a_no_result_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !s1_valid_q) |=> !out_valid_o)
    else $error("result appeared without an item");

endmodule

`default_nettype wire

FILE: rtl/lse_bit_merge.sv
// Merges the low bits of one carrier byte into the field accumulator and
// carries leftover bits into the next field. Depends on lse_pkg.
`default_nettype none

module lse_bit_merge import lse_pkg::*; (
  input  logic [3:0]  k_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] acc_i,
  input  cnt_t        cnt_i,
  input  logic        wide_i,
  output logic        done_o,
  output logic [31:0] merged_o,
  output logic [31:0] acc_next_o,
  output cnt_t        cnt_next_o
);

  cnt_t       width;
  cnt_t       rem;
  logic [3:0] take;
  logic [3:0] left;
  logic [7:0] take_mask;
  logic [7:0] left_mask;
  logic [7:0] left_bits;

  always_comb begin
    width      = wide_i ? CntW'(HdrWordBits) : CntW'(ByteBits);
    rem        = width - cnt_i;
    done_o     = CntW'(k_i) >= rem;
    take       = done_o ? rem[3:0] : k_i;
    left       = k_i - take;
    take_mask  = 8'((9'd1 << take) - 9'd1);
    left_mask  = 8'((9'd1 << left) - 9'd1);
    left_bits  = (byte_i >> take) & left_mask;
    merged_o   = acc_i | (32'(byte_i & take_mask) << cnt_i);
    acc_next_o = done_o ? 32'(left_bits) : merged_o;
    cnt_next_o = done_o ? CntW'(left) : cnt_i + CntW'(k_i);
  end

endmodule

`default_nettype wire

FILE: rtl/lse_ctrl.sv
// Extraction state: phase, bit count, accumulator, header index and payload
// counter; builds at most one result per item. Depends on lse_pkg and lse_bit_merge.
`default_nettype none

module lse_ctrl import lse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       start_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  k_q, k_d;
  logic [31:0] acc_q, acc_d;
  cnt_t        cnt_q, cnt_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [31:0] left_q, left_d;

  logic [3:0]  k_full;
  logic        wide;
  logic        done;
  logic [31:0] merged;
  logic [31:0] acc_next;
  cnt_t        cnt_next;

  assign wide   = (phase_q == PhHeader) && (hidx_q != 3'd0);
  assign k_full = {byte_i[1:0], k_q[1:0]};

  lse_bit_merge u_merge (
    .k_i        (k_q),
    .byte_i     (byte_i),
    .acc_i      (acc_q),
    .cnt_i      (cnt_q),
    .wide_i     (wide),
    .done_o     (done),
    .merged_o   (merged),
    .acc_next_o (acc_next),
    .cnt_next_o (cnt_next)
  );

  always_comb begin
    phase_d     = phase_q;
    k_d         = k_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    hidx_d      = hidx_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindError, value: 32'd0, last: 1'b0};
    if (start_i) begin
      phase_d = PhCount;
      k_d     = {2'b00, byte_i[1:0]};
      acc_d   = 32'd0;
      cnt_d   = '0;
      hidx_d  = 3'd0;
      left_d  = 32'd0;
    end else begin
      unique case (phase_q)
        PhCount: begin
          k_d    = k_full;
          acc_d  = 32'd0;
          cnt_d  = '0;
          hidx_d = 3'd0;
          if ((k_full == 4'd0) || (k_full > MaxBitsPerCarrier)) begin
            phase_d     = PhDone;
            res_valid_o = 1'b1;
            res_o.last  = 1'b1;
          end else begin
            phase_d = PhHeader;
          end
        end
        PhHeader: begin
          acc_d = acc_next;
          cnt_d = cnt_next;
          if (done) begin
            res_valid_o = 1'b1;
            res_o.kind  = kind_e'(hidx_q);
            res_o.value = merged;
            hidx_d      = hidx_q + 3'd1;
            if (hidx_q == LastHdrIdx) begin
              left_d = merged;
              if (merged == 32'd0) begin
                res_o.last = 1'b1;
                phase_d    = PhDone;
              end else begin
                phase_d = PhPayload;
              end
            end
          end
        end
        PhPayload: begin
          acc_d = acc_next;
          cnt_d = cnt_next;
          if (done) begin
            res_valid_o = 1'b1;
            res_o.kind  = KindPayload;
            res_o.value = {24'd0, merged[7:0]};
            left_d      = left_q - 32'd1;
            if (left_q == 32'd1) begin
              res_o.last = 1'b1;
              phase_d    = PhDone;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      k_q     <= 4'd0;
      acc_q   <= 32'd0;
      cnt_q   <= '0;
      hidx_q  <= 3'd0;
      left_q  <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      k_q     <= k_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hidx_q  <= hidx_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for lsb_stego_extract_unit: streams well-formed, broken and bad-count carrier images
// and checks every result against a scoreboard that predicts the extraction bit by bit.
// Depends on lse_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import lse_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned StreamItems = 800;
  localparam int unsigned HoldOffStart = 700;
  localparam int unsigned HoldOffLength = 300;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } carrier_t;

  class extract_scoreboard;
    phase_e      phase;
    logic [3:0]  bits_per_byte;
    logic [31:0] acc;
    int unsigned acc_bits;
    logic [2:0]  hdr_idx;
    logic [31:0] bytes_left;
    res_t        expected_q[$];
    int unsigned errors;

    function new();
      phase = PhIdle;
      bits_per_byte = '0;
      acc = '0;
      acc_bits = 0;
      hdr_idx = '0;
      bytes_left = '0;
      errors = 0;
    endfunction

    function void push_result(kind_e k, logic [31:0] v, logic l);
      res_t r;
      r.kind = k;
      r.value = v;
      r.last = l;
      expected_q = {expected_q, r};
    endfunction

    function void note_item(logic start, logic [7:0] b);
      int unsigned width;
      logic        fin;
      if (start) begin
        phase = PhCount;
        bits_per_byte = {2'b00, b[1:0]};
        acc = '0;
        acc_bits = 0;
        hdr_idx = '0;
        bytes_left = '0;
        return;
      end
      if (phase == PhCount) begin
        bits_per_byte[3:2] = b[1:0];
        if (bits_per_byte == 4'd0 || bits_per_byte > MaxBitsPerCarrier) begin
          phase = PhDone;
          push_result(KindError, 32'd0, 1'b1);
        end else begin
          phase = PhHeader;
          acc = '0;
          acc_bits = 0;
          hdr_idx = '0;
        end
        return;
      end
      if (phase != PhHeader && phase != PhPayload) return;
      for (int i = 0; i < int'(bits_per_byte); i++) begin
        if (phase != PhHeader && phase != PhPayload) break;
        if (acc_bits < 32) acc[acc_bits] = b[i];
        acc_bits++;
        width = (phase == PhPayload || hdr_idx == 3'd0) ? ByteBits : HdrWordBits;
        if (acc_bits < width) continue;
        fin = 1'b0;
        if (phase == PhHeader) begin
          if (hdr_idx == LastHdrIdx) begin
            bytes_left = acc;
            if (acc == 32'd0) begin
              fin = 1'b1;
              phase = PhDone;
            end else begin
              phase = PhPayload;
            end
          end
          push_result(kind_e'(hdr_idx), acc, fin);
          hdr_idx++;
        end else begin
          bytes_left--;
          if (bytes_left == 32'd0) begin
            fin = 1'b1;
            phase = PhDone;
          end
          push_result(KindPayload, {24'd0, acc[7:0]}, fin);
        end
        acc = '0;
        acc_bits = 0;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [31:0] value, logic last);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d value %h last %0b", kind, value, last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $error("value: expected %h, actual %h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      foreach (expected_q[n]) begin
        $error("missing result: kind %0d value %h last %0b",
               expected_q[n].kind, expected_q[n].value, expected_q[n].last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        start_req_i;
  logic [7:0]  carrier_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [31:0] value_o;
  logic        last_o;

  extract_scoreboard sb = new();
  carrier_t          stim_q[$];
  int unsigned       image_items;
  int unsigned       cycles;

  lsb_stego_extract_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_req_i   (start_req_i),
    .carrier_byte_i(carrier_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic start, logic [7:0] b);
    carrier_t c;
    c.start = start;
    c.data = b;
    stim_q = {stim_q, c};
  endtask

  task automatic add_image(logic [3:0] k, logic [7:0] info, logic [4:0][31:0] hdr,
                           int unsigned npay, int unsigned cut);
    bit          bit_q[$];
    logic [7:0]  rb;
    logic [7:0]  pay;
    int unsigned sent;
    for (int i = 0; i < 8; i++) bit_q = {bit_q, info[i]};
    for (int w = 0; w < 5; w++)
      for (int i = 0; i < int'(HdrWordBits); i++)
        bit_q = {bit_q, (i < 32) ? hdr[w][i] : 1'b0};
    for (int p = 0; p < int'(npay); p++) begin
      pay = 8'($urandom);
      for (int i = 0; i < 8; i++) bit_q = {bit_q, pay[i]};
    end
    rb = 8'($urandom);
    rb[1:0] = k[1:0];
    add_item(1'b1, rb);
    rb = 8'($urandom);
    rb[1:0] = k[3:2];
    add_item(1'b0, rb);
    sent = 2;
    while (bit_q.size() > 0 && (cut == 0 || sent < cut) && k != 4'd0 && k <= 4'd8) begin
      rb = 8'($urandom);
      for (int i = 0; i < int'(k); i++)
        if (bit_q.size() > 0) rb[i] = bit_q.pop_front();
      add_item(1'b0, rb);
      sent++;
    end
    image_items += sent;
  endtask

  task automatic build_stimulus();
    logic [4:0][31:0] hdr;
    logic [3:0]       k;
    int unsigned      r;
    int unsigned      npay;
    int unsigned      full_len;
    add_item(1'b0, 8'h00);
    add_item(1'b0, 8'hFF);
    add_item(1'b1, 8'hFC);
    add_item(1'b0, 8'h00);
    add_item(1'b0, 8'hFF);
    add_item(1'b1, 8'hFF);
    add_item(1'b0, 8'hFF);
    add_item(1'b1, 8'h01);
    add_item(1'b0, 8'h02);
    add_item(1'b1, 8'h03);
    hdr = {32'd1, 32'h8000_0001, 32'd24, 32'd0, 32'hFFFF_FFFF};
    add_image(4'd8, 8'hFF, hdr, 1, 0);
    image_items = 0;
    while (image_items < StreamItems) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) k = 4'($urandom_range(1, 3));
      else k = 4'($urandom_range(4, 8));
      for (int w = 0; w < 5; w++) hdr[w] = pick_word();
      npay = $urandom_range(0, 6);
      if (r < 70) begin
        hdr[4] = npay;
        add_image(k, 8'(pick_word()), hdr, npay, 0);
      end else if (r < 82) begin
        npay = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 1) hdr[4] = $urandom | 32'h100;
        else hdr[4] = npay;
        full_len = 2 + (8 + 5 * HdrWordBits + 8 * npay + k - 1) / k;
        add_image(k, 8'(pick_word()), hdr, npay, $urandom_range(3, full_len - 1));
      end else if (r < 92) begin
        k = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        add_image(k, 8'h00, hdr, 0, 0);
      end
      repeat ($urandom_range(0, 2)) add_item(1'b0, 8'($urandom));
    end
  endtask

  task automatic send_stream();
    int unsigned gap;
    bit          calm;
    calm = 1'b0;
    foreach (stim_q[n]) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      start_req_i <= stim_q[n].start;
      carrier_byte_i <= stim_q[n].data;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_item(stim_q[n].start, stim_q[n].data);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned rx_cycles;
    int unsigned hold;
    int unsigned stall_left;
    bit          calm;
    rx_cycles = 0;
    hold = 0;
    stall_left = 0;
    calm = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (rx_cycles % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (rx_cycles == HoldOffStart) hold = HoldOffLength;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(kind_o, value_o, last_o);
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_req_i = 1'b0;
    carrier_byte_i = 8'h00;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_stream();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
